@@ rtl/sms_pkg.sv @@
package sms_pkg;

   // Default build values
   localparam int unsigned PAIR_COUNT_DEF            = 4;
   localparam int unsigned TICK_PERIOD_Q16_DEF       = 66;
   localparam int unsigned CURRENT_LIMIT_Q16_DEF     = 655360;
   localparam int unsigned INTEGRAL_LIMIT_Q16_DEF    = 655360;
   localparam int unsigned DISTURBANCE_LIMIT_Q16_DEF = 6553600;
   localparam int unsigned OBSERVER_ON_DEF           = 1;

   // Fixed-point constants
   localparam int unsigned ONE_Q16        = 65536;
   localparam int unsigned RPM_TO_RAD_Q16 = 6863;

   // Register file layout
   localparam int unsigned NUM_REGS  = 8;
   localparam int unsigned REG_BITS  = 31;
   localparam int unsigned DATA_BITS = 32;
   localparam int unsigned ADDR_BITS = 5;

   localparam logic [2:0] REG_SLOPE   = 3'd0;
   localparam logic [2:0] REG_LIN     = 3'd1;
   localparam logic [2:0] REG_SWITCH  = 3'd2;
   localparam logic [2:0] REG_BOUND   = 3'd3;
   localparam logic [2:0] REG_K1      = 3'd4;
   localparam logic [2:0] REG_K2      = 3'd5;
   localparam logic [2:0] REG_DAMP    = 3'd6;
   localparam logic [2:0] REG_DGAIN   = 3'd7;

   typedef logic signed [31:0] q16_type;
   typedef logic signed [63:0] wide_type;

   // Saturate to 32-bit signed
   function automatic q16_type sat32(input wide_type v);
      q16_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Clamp to +-lim
   function automatic wide_type clamp_sym(input wide_type v, input wide_type lim);
      wide_type r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Sign as +-1.0 or zero
   function automatic q16_type sign_q(input q16_type v);
      q16_type r;
      if (v > 32'sd0) begin
         r = 32'sd65536;
      end else if (v < 32'sd0) begin
         r = -32'sd65536;
      end else begin
         r = 32'sd0;
      end
      return r;
   endfunction

endpackage

@@ rtl/sliding_mode_speed_controller_top.sv @@
// Throughput: one item at a time; the next item is taken once the result sits in the output
// register. The time per item is set by the shared bit-serial divider (up to five quotients per
// item) and the bit-pair square root.
// Reset (synchronous, active high): registers take their reset values, the integrator and
// observer go unprimed with zero state, and no result is pending.
module sliding_mode_speed_controller_top #(
   parameter int unsigned PAIR_COUNT            = sms_pkg::PAIR_COUNT_DEF,
   parameter int unsigned TICK_PERIOD_Q16       = sms_pkg::TICK_PERIOD_Q16_DEF,
   parameter int unsigned CURRENT_LIMIT_Q16     = sms_pkg::CURRENT_LIMIT_Q16_DEF,
   parameter int unsigned INTEGRAL_LIMIT_Q16    = sms_pkg::INTEGRAL_LIMIT_Q16_DEF,
   parameter int unsigned DISTURBANCE_LIMIT_Q16 = sms_pkg::DISTURBANCE_LIMIT_Q16_DEF,
   parameter int unsigned OBSERVER_ON           = sms_pkg::OBSERVER_ON_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [31:0]             req_speed_target_rpm,
   input  logic signed [31:0]             req_speed_measured_rpm,
   input  logic signed [31:0]             req_current_measured,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_current_command,
   output logic signed [31:0]             rsp_surface_value,
   output logic signed [31:0]             rsp_disturbance_estimate,
   output logic signed [31:0]             rsp_speed_estimate,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sms_pkg::ADDR_BITS-1:0]  csr_paddr,
   input  logic [sms_pkg::DATA_BITS-1:0]  csr_pwdata,
   output logic [sms_pkg::DATA_BITS-1:0]  csr_prdata,
   output logic                           csr_pready
);
   import sms_pkg::*;

   localparam logic [30:0]        MECH_DIV = 31'(ONE_Q16 * PAIR_COUNT);
   localparam logic signed [31:0] TICK_Q   = 32'(TICK_PERIOD_Q16);
   localparam logic signed [31:0] RPM_K    = 32'(RPM_TO_RAD_Q16);
   localparam wide_type CLIM = 64'(CURRENT_LIMIT_Q16);
   localparam wide_type ILIM = 64'(INTEGRAL_LIMIT_Q16);
   localparam wide_type DLIM = 64'(DISTURBANCE_LIMIT_Q16);
   localparam wide_type SLIM = 64'(ONE_Q16);
   localparam logic OBS_EN = (OBSERVER_ON != 0);

   localparam int unsigned DIV_BITS = 51;
   localparam int unsigned SQ_STEPS = 24;

   // Sequencer states
   localparam logic [5:0] ST_IDLE      = 6'd0;
   localparam logic [5:0] ST_MUL_T     = 6'd1;
   localparam logic [5:0] ST_DIV_T_GO  = 6'd2;
   localparam logic [5:0] ST_DIV_T_WT  = 6'd3;
   localparam logic [5:0] ST_MUL_F     = 6'd4;
   localparam logic [5:0] ST_DIV_F_GO  = 6'd5;
   localparam logic [5:0] ST_DIV_F_WT  = 6'd6;
   localparam logic [5:0] ST_OBS_INIT  = 6'd7;
   localparam logic [5:0] ST_OBS_ERR   = 6'd8;
   localparam logic [5:0] ST_OBS_SV    = 6'd9;
   localparam logic [5:0] ST_OBS_SV_WT = 6'd10;
   localparam logic [5:0] ST_OBS_SQ    = 6'd11;
   localparam logic [5:0] ST_OBS_SQ_WT = 6'd12;
   localparam logic [5:0] ST_OBS_M1    = 6'd13;
   localparam logic [5:0] ST_OBS_Q1    = 6'd14;
   localparam logic [5:0] ST_OBS_M2    = 6'd15;
   localparam logic [5:0] ST_OBS_V1    = 6'd16;
   localparam logic [5:0] ST_OBS_V2    = 6'd17;
   localparam logic [5:0] ST_OBS_A1    = 6'd18;
   localparam logic [5:0] ST_OBS_A2    = 6'd19;
   localparam logic [5:0] ST_OBS_A3    = 6'd20;
   localparam logic [5:0] ST_OBS_M3    = 6'd21;
   localparam logic [5:0] ST_OBS_UPD1  = 6'd22;
   localparam logic [5:0] ST_OBS_UPD2  = 6'd23;
   localparam logic [5:0] ST_ERR       = 6'd24;
   localparam logic [5:0] ST_INT_M     = 6'd25;
   localparam logic [5:0] ST_INT_UPD   = 6'd26;
   localparam logic [5:0] ST_SURF_M    = 6'd27;
   localparam logic [5:0] ST_SURF      = 6'd28;
   localparam logic [5:0] ST_SURF_SAT  = 6'd29;
   localparam logic [5:0] ST_SURF_WT   = 6'd30;
   localparam logic [5:0] ST_REACH_M1  = 6'd31;
   localparam logic [5:0] ST_REACH_M2  = 6'd32;
   localparam logic [5:0] ST_REACH     = 6'd33;
   localparam logic [5:0] ST_NUM       = 6'd34;
   localparam logic [5:0] ST_CMD_GO    = 6'd35;
   localparam logic [5:0] ST_CMD_WT    = 6'd36;
   localparam logic [5:0] ST_OUT       = 6'd37;

   logic [5:0]  state_ff;
   logic [30:0] cfg_ff [NUM_REGS];

   q16_type tgt_ff, meas_ff, iq_ff, ref_ff, fbk_ff;
   q16_type oerr_ff, sv_ff, tmp_ff, v1_ff, v2_ff, err_ff, s_ff, ss_ff, cmd_ff;
   q16_type integ_ff, ospd_ff, odist_ff;
   logic    oprimed_ff, iprimed_ff;
   logic signed [35:0] acc_ff;
   wide_type prod_ff;

   logic    rsp_valid_ff;
   q16_type rsp_cmd_ff, rsp_surf_ff, rsp_dist_ff, rsp_spd_ff;

   q16_type c_q, q_q, eps_q, k1_q, k2_q, bj_q, dg_q;
   logic    bound_zero, dgain_zero;

   assign c_q   = 32'(cfg_ff[REG_SLOPE]);
   assign q_q   = 32'(cfg_ff[REG_LIN]);
   assign eps_q = 32'(cfg_ff[REG_SWITCH]);
   assign k1_q  = 32'(cfg_ff[REG_K1]);
   assign k2_q  = 32'(cfg_ff[REG_K2]);
   assign bj_q  = 32'(cfg_ff[REG_DAMP]);
   assign dg_q  = 32'(cfg_ff[REG_DGAIN]);
   assign bound_zero = (cfg_ff[REG_BOUND] == 31'd0);
   assign dgain_zero = (cfg_ff[REG_DGAIN] == 31'd0);

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= (3'(i) == REG_DGAIN) ? 31'(ONE_Q16) : 31'd0;
         end
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         cfg_ff[csr_paddr[4:2]] <= csr_pwdata[30:0];
      end
   end

   assign csr_prdata = {1'b0, cfg_ff[csr_paddr[4:2]]};
   assign csr_pready = 1'b1;

   // Shared multiplier, registered product
   q16_type mul_a, mul_b;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_T:    begin mul_a = tgt_ff;  mul_b = RPM_K;   end
         ST_MUL_F:    begin mul_a = meas_ff; mul_b = RPM_K;   end
         ST_OBS_M1:   begin mul_a = k1_q;    mul_b = tmp_ff;  end
         ST_OBS_M2:   begin mul_a = tmp_ff;  mul_b = sv_ff;   end
         ST_OBS_V1:   begin mul_a = k2_q;    mul_b = sv_ff;   end
         ST_OBS_V2:   begin mul_a = dg_q;    mul_b = iq_ff;   end
         ST_OBS_A1:   begin mul_a = bj_q;    mul_b = ospd_ff; end
         ST_OBS_M3:   begin mul_a = tmp_ff;  mul_b = TICK_Q;  end
         ST_OBS_UPD1: begin mul_a = v2_ff;   mul_b = TICK_Q;  end
         ST_INT_M:    begin mul_a = err_ff;  mul_b = TICK_Q;  end
         ST_SURF_M:   begin mul_a = c_q;     mul_b = integ_ff; end
         ST_REACH_M1: begin mul_a = q_q;     mul_b = s_ff;    end
         ST_REACH_M2: begin mul_a = eps_q;   mul_b = ss_ff;   end
         ST_REACH:    begin mul_a = bj_q;    mul_b = fbk_ff;  end
         default:     begin mul_a = '0;      mul_b = '0;      end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // Scale the product back to Q16.16, truncating toward zero
   wide_type prod_adj;
   q16_type  qm;
   assign prod_adj = prod_ff + (prod_ff[63] ? 64'sd65535 : 64'sd0);
   assign qm       = sat32(prod_adj >>> 16);

   // Bit-serial restoring divider
   logic           div_go;
   wide_type       div_num;
   logic [30:0]    div_den;
   logic           div_busy_ff, div_neg_ff;
   logic [5:0]     div_cnt_ff;
   logic [DIV_BITS-1:0] div_quo_ff;
   logic [31:0]    div_rem_ff;
   logic [30:0]    div_den_ff;
   wide_type       div_mag;
   logic [31:0]    div_sh;
   wide_type       div_res;

   always_comb begin
      div_go  = 1'b0;
      div_num = prod_ff;
      div_den = MECH_DIV;
      unique case (state_ff)
         ST_DIV_T_GO, ST_DIV_F_GO: begin
            div_go = 1'b1;
         end
         ST_OBS_SV: begin
            div_go  = !bound_zero;
            div_num = {{16{oerr_ff[31]}}, oerr_ff, 16'h0};
            div_den = cfg_ff[REG_BOUND];
         end
         ST_SURF_SAT: begin
            div_go  = !bound_zero;
            div_num = {{16{s_ff[31]}}, s_ff, 16'h0};
            div_den = cfg_ff[REG_BOUND];
         end
         ST_CMD_GO: begin
            div_go  = !dgain_zero;
            div_num = {{12{acc_ff[35]}}, acc_ff, 16'h0};
            div_den = cfg_ff[REG_DGAIN];
         end
         default: begin
            div_go = 1'b0;
         end
      endcase
   end

   assign div_mag = div_num[63] ? -div_num : div_num;
   assign div_sh  = {div_rem_ff[30:0], div_quo_ff[DIV_BITS-1]};
   assign div_res = div_neg_ff ? -$signed({13'b0, div_quo_ff})
                               : $signed({13'b0, div_quo_ff});

   // Shift one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (div_go) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 6'd1;
         if (div_cnt_ff == 6'(DIV_BITS - 1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_go) begin
         div_neg_ff <= div_num[63];
         div_quo_ff <= div_mag[DIV_BITS-1:0];
         div_rem_ff <= '0;
         div_den_ff <= div_den;
      end else if (div_busy_ff) begin
         if (div_sh >= {1'b0, div_den_ff}) begin
            div_rem_ff <= div_sh - {1'b0, div_den_ff};
            div_quo_ff <= {div_quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_sh;
            div_quo_ff <= {div_quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
   end

   // Bit-pair square root, one root bit per cycle
   logic        sq_go, sq_busy_ff;
   logic [4:0]  sq_cnt_ff;
   logic [47:0] sq_rad_ff;
   logic [25:0] sq_rem_ff, sq_sh, sq_trial;
   logic [23:0] sq_root_ff;
   logic [31:0] oerr_abs;

   assign sq_go    = (state_ff == ST_OBS_SQ);
   assign oerr_abs = oerr_ff[31] ? 32'(-oerr_ff) : 32'(oerr_ff);
   assign sq_sh    = {sq_rem_ff[23:0], sq_rad_ff[47:46]};
   assign sq_trial = {sq_root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_cnt_ff  <= '0;
      end else if (sq_go) begin
         sq_busy_ff <= 1'b1;
         sq_cnt_ff  <= '0;
      end else if (sq_busy_ff) begin
         sq_cnt_ff <= sq_cnt_ff + 5'd1;
         if (sq_cnt_ff == 5'(SQ_STEPS - 1)) begin
            sq_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_go) begin
         sq_rad_ff  <= {oerr_abs, 16'h0};
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
      end else if (sq_busy_ff) begin
         sq_rad_ff <= {sq_rad_ff[45:0], 2'b00};
         if (sq_sh >= sq_trial) begin
            sq_rem_ff  <= sq_sh - sq_trial;
            sq_root_ff <= {sq_root_ff[22:0], 1'b1};
         end else begin
            sq_rem_ff  <= sq_sh;
            sq_root_ff <= {sq_root_ff[22:0], 1'b0};
         end
      end
   end

   // Sequencer and controller state
   logic load_out;
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         integ_ff   <= '0;
         ospd_ff    <= '0;
         odist_ff   <= '0;
         oprimed_ff <= 1'b0;
         iprimed_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  tgt_ff   <= req_speed_target_rpm;
                  meas_ff  <= req_speed_measured_rpm;
                  iq_ff    <= req_current_measured;
                  state_ff <= ST_MUL_T;
               end
            end
            ST_MUL_T:    state_ff <= ST_DIV_T_GO;
            ST_DIV_T_GO: state_ff <= ST_DIV_T_WT;
            ST_DIV_T_WT: begin
               if (!div_busy_ff) begin
                  ref_ff   <= div_res[31:0];
                  state_ff <= ST_MUL_F;
               end
            end
            ST_MUL_F:    state_ff <= ST_DIV_F_GO;
            ST_DIV_F_GO: state_ff <= ST_DIV_F_WT;
            ST_DIV_F_WT: begin
               if (!div_busy_ff) begin
                  fbk_ff <= div_res[31:0];
                  if (OBS_EN && oprimed_ff) begin
                     state_ff <= ST_OBS_ERR;
                  end else begin
                     state_ff <= ST_OBS_INIT;
                  end
               end
            end
            // Load the observer with the measured speed
            ST_OBS_INIT: begin
               ospd_ff    <= fbk_ff;
               odist_ff   <= '0;
               oprimed_ff <= OBS_EN;
               state_ff   <= ST_ERR;
            end
            ST_OBS_ERR: begin
               oerr_ff  <= sat32(64'(ospd_ff) - 64'(fbk_ff));
               state_ff <= ST_OBS_SV;
            end
            ST_OBS_SV: begin
               if (bound_zero) begin
                  sv_ff    <= sign_q(oerr_ff);
                  state_ff <= ST_OBS_SQ;
               end else begin
                  state_ff <= ST_OBS_SV_WT;
               end
            end
            ST_OBS_SV_WT: begin
               if (!div_busy_ff) begin
                  sv_ff    <= 32'(clamp_sym(div_res, SLIM));
                  state_ff <= ST_OBS_SQ;
               end
            end
            ST_OBS_SQ:    state_ff <= ST_OBS_SQ_WT;
            ST_OBS_SQ_WT: begin
               if (!sq_busy_ff) begin
                  tmp_ff   <= 32'(sq_root_ff);
                  state_ff <= ST_OBS_M1;
               end
            end
            ST_OBS_M1: state_ff <= ST_OBS_Q1;
            ST_OBS_Q1: begin
               tmp_ff   <= qm;
               state_ff <= ST_OBS_M2;
            end
            ST_OBS_M2: state_ff <= ST_OBS_V1;
            ST_OBS_V1: begin
               v1_ff    <= sat32(-64'(qm));
               state_ff <= ST_OBS_V2;
            end
            ST_OBS_V2: begin
               v2_ff    <= sat32(-64'(qm));
               state_ff <= ST_OBS_A1;
            end
            ST_OBS_A1: begin
               acc_ff   <= 36'(qm);
               state_ff <= ST_OBS_A2;
            end
            ST_OBS_A2: begin
               acc_ff   <= acc_ff - 36'(qm) + 36'(odist_ff) + 36'(v1_ff);
               state_ff <= ST_OBS_A3;
            end
            ST_OBS_A3: begin
               tmp_ff   <= sat32(64'(acc_ff));
               state_ff <= ST_OBS_M3;
            end
            ST_OBS_M3: state_ff <= ST_OBS_UPD1;
            ST_OBS_UPD1: begin
               ospd_ff  <= sat32(64'(ospd_ff) + 64'(qm));
               state_ff <= ST_OBS_UPD2;
            end
            ST_OBS_UPD2: begin
               odist_ff <= 32'(clamp_sym(64'(odist_ff) + 64'(qm), DLIM));
               state_ff <= ST_ERR;
            end
            // Speed error and integrator
            ST_ERR: begin
               err_ff <= sat32(64'(ref_ff) - 64'(fbk_ff));
               if (!iprimed_ff) begin
                  integ_ff   <= '0;
                  iprimed_ff <= 1'b1;
                  state_ff   <= ST_SURF_M;
               end else begin
                  state_ff <= ST_INT_M;
               end
            end
            ST_INT_M: state_ff <= ST_INT_UPD;
            ST_INT_UPD: begin
               integ_ff <= 32'(clamp_sym(64'(integ_ff) + 64'(qm), ILIM));
               state_ff <= ST_SURF_M;
            end
            ST_SURF_M: state_ff <= ST_SURF;
            ST_SURF: begin
               s_ff     <= sat32(64'(qm) + 64'(err_ff));
               state_ff <= ST_SURF_SAT;
            end
            ST_SURF_SAT: begin
               if (bound_zero) begin
                  ss_ff    <= sign_q(s_ff);
                  state_ff <= ST_REACH_M1;
               end else begin
                  state_ff <= ST_SURF_WT;
               end
            end
            ST_SURF_WT: begin
               if (!div_busy_ff) begin
                  ss_ff    <= 32'(clamp_sym(div_res, SLIM));
                  state_ff <= ST_REACH_M1;
               end
            end
            // Reaching law and command numerator
            ST_REACH_M1: state_ff <= ST_REACH_M2;
            ST_REACH_M2: begin
               acc_ff   <= 36'(qm);
               state_ff <= ST_REACH;
            end
            ST_REACH: begin
               acc_ff   <= 36'(sat32(64'(acc_ff) + 64'(qm)));
               state_ff <= ST_NUM;
            end
            ST_NUM: begin
               acc_ff   <= acc_ff + 36'(qm) - 36'(odist_ff);
               state_ff <= ST_CMD_GO;
            end
            ST_CMD_GO: begin
               if (dgain_zero) begin
                  cmd_ff   <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_CMD_WT;
               end
            end
            ST_CMD_WT: begin
               if (!div_busy_ff) begin
                  cmd_ff   <= 32'(clamp_sym(div_res, CLIM));
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (load_out) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Output register: hold the result until the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_cmd_ff  <= cmd_ff;
         rsp_surf_ff <= s_ff;
         rsp_dist_ff <= odist_ff;
         rsp_spd_ff  <= ospd_ff;
      end
   end

   assign req_ready                = (state_ff == ST_IDLE);
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_current_command      = rsp_cmd_ff;
   assign rsp_surface_value        = rsp_surf_ff;
   assign rsp_disturbance_estimate = rsp_dist_ff;
   assign rsp_speed_estimate       = rsp_spd_ff;

endmodule

@@ bench/sliding_mode_speed_controller_top_tb.sv @@
`timescale 1ns / 1ps

module sliding_mode_speed_controller_top_tb;
   import sms_pkg::*;

   localparam int unsigned OBS_TICK    = TICK_PERIOD_Q16_DEF;
   localparam longint      CMD_LIMIT   = CURRENT_LIMIT_Q16_DEF;
   localparam longint      INT_LIMIT   = INTEGRAL_LIMIT_Q16_DEF;
   localparam longint      DIST_LIMIT  = DISTURBANCE_LIMIT_Q16_DEF;
   localparam longint      ONE         = ONE_Q16;
   localparam int          IDLE_MAX    = 13;
   localparam int          SETTLE_CYC  = 400;

   typedef struct packed {
      q16_type target_rpm;
      q16_type measured_rpm;
      q16_type current_q;
   } tick_in_type;

   typedef struct packed {
      q16_type command;
      q16_type surface;
      q16_type disturbance;
      q16_type speed;
   } tick_out_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   q16_type req_speed_target_rpm;
   q16_type req_speed_measured_rpm;
   q16_type req_current_measured;
   logic rsp_valid;
   logic rsp_ready;
   q16_type rsp_current_command;
   q16_type rsp_surface_value;
   q16_type rsp_disturbance_estimate;
   q16_type rsp_speed_estimate;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [DATA_BITS-1:0] csr_pwdata;
   logic [DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   sliding_mode_speed_controller_top u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_speed_target_rpm     (req_speed_target_rpm),
      .req_speed_measured_rpm   (req_speed_measured_rpm),
      .req_current_measured     (req_current_measured),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_current_command      (rsp_current_command),
      .rsp_surface_value        (rsp_surface_value),
      .rsp_disturbance_estimate (rsp_disturbance_estimate),
      .rsp_speed_estimate       (rsp_speed_estimate),
      .csr_psel                 (csr_psel),
      .csr_penable              (csr_penable),
      .csr_pwrite               (csr_pwrite),
      .csr_paddr                (csr_paddr),
      .csr_pwdata               (csr_pwdata),
      .csr_prdata               (csr_prdata),
      .csr_pready               (csr_pready)
   );

   // Controller model state
   longint gain_reg [NUM_REGS];
   longint err_integral;
   longint obs_speed;
   longint obs_dist;
   bit     obs_primed;
   bit     int_primed;

   tick_in_type  pending_ticks [$];
   tick_out_type expected_ticks [$];
   int        mismatch_count = 0;
   bit        hold_off_req;
   int        hold_off_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return clip32((a * b) / ONE);
   endfunction

   function automatic longint soft_sign(longint x, longint width);
      if (width == 0) return (x > 0) ? ONE : ((x < 0) ? -ONE : 0);
      return clip_sym((x * ONE) / width, ONE);
   endfunction

   function automatic longint int_root(longint x);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         longint t;
         t = r | (64'sd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic longint rpm_to_rad(q16_type rpm);
      return clip32((longint'(rpm) * longint'(RPM_TO_RAD_Q16))
                    / (ONE * longint'(PAIR_COUNT_DEF)));
   endfunction

   function automatic void clear_loop_state();
      err_integral = 0;
      obs_speed    = 0;
      obs_dist     = 0;
      obs_primed   = 1'b0;
      int_primed   = 1'b0;
   endfunction

   // Advance the controller one speed-loop tick
   function automatic tick_out_type predict_tick(tick_in_type t);
      tick_out_type o;
      longint ref_w, fbk, iq, e, s, reach, comp, cmd, num;
      longint oerr, sv, root, v1, v2, accel;
      ref_w = rpm_to_rad(t.target_rpm);
      fbk   = rpm_to_rad(t.measured_rpm);
      iq    = t.current_q;
      if (OBSERVER_ON_DEF != 0) begin
         if (!obs_primed) begin
            obs_speed  = fbk;
            obs_dist   = 0;
            obs_primed = 1'b1;
         end else begin
            oerr  = clip32(obs_speed - fbk);
            sv    = soft_sign(oerr, gain_reg[REG_BOUND]);
            root  = int_root(((oerr < 0) ? -oerr : oerr) << 16);
            v1    = clip32(-fx_mul(fx_mul(gain_reg[REG_K1], root), sv));
            v2    = clip32(-fx_mul(gain_reg[REG_K2], sv));
            accel = clip32(fx_mul(gain_reg[REG_DGAIN], iq)
                           - fx_mul(gain_reg[REG_DAMP], obs_speed) + obs_dist + v1);
            obs_speed = clip32(obs_speed + fx_mul(accel, OBS_TICK));
            obs_dist  = clip_sym(obs_dist + fx_mul(v2, OBS_TICK), DIST_LIMIT);
         end
         comp = obs_dist;
      end else begin
         obs_speed  = fbk;
         obs_dist   = 0;
         obs_primed = 1'b0;
         comp       = 0;
      end
      e = clip32(ref_w - fbk);
      if (!int_primed) begin
         err_integral = 0;
         int_primed   = 1'b1;
      end else begin
         err_integral = clip_sym(err_integral + fx_mul(e, OBS_TICK), INT_LIMIT);
      end
      s     = clip32(fx_mul(gain_reg[REG_SLOPE], err_integral) + e);
      reach = clip32(fx_mul(gain_reg[REG_LIN], s)
                     + fx_mul(gain_reg[REG_SWITCH], soft_sign(s, gain_reg[REG_BOUND])));
      if (gain_reg[REG_DGAIN] == 0) begin
         cmd = 0;
      end else begin
         num = reach + fx_mul(gain_reg[REG_DAMP], fbk) - comp;
         cmd = clip_sym((num * ONE) / gain_reg[REG_DGAIN], CMD_LIMIT);
      end
      o.command     = q16_type'(cmd);
      o.surface     = q16_type'(s);
      o.disturbance = q16_type'(obs_dist);
      o.speed       = q16_type'(obs_speed);
      return o;
   endfunction

   // Driver: present queued ticks with random gaps
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (req_valid && !req_ready) begin
         // hold payload until the transfer
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (pending_ticks.size() > 0) begin
         tick_in_type t;
         t = pending_ticks.pop_front();
         expected_ticks.push_back(predict_tick(t));
         req_valid              <= 1'b1;
         req_speed_target_rpm   <= t.target_rpm;
         req_speed_measured_rpm <= t.measured_rpm;
         req_current_measured   <= t.current_q;
         req_gap                <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Monitor: compare each result transfer with the oldest expectation
   int rsp_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_ticks.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected result cmd=%0d s=%0d", rsp_current_command,
                           rsp_surface_value);
            end else begin
               tick_out_type exp_o;
               exp_o = expected_ticks.pop_front();
               if (exp_o.command !== rsp_current_command ||
                   exp_o.surface !== rsp_surface_value ||
                   exp_o.disturbance !== rsp_disturbance_estimate ||
                   exp_o.speed !== rsp_speed_estimate) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("exp cmd/s/d/w %0d %0d %0d %0d got %0d %0d %0d %0d",
                              exp_o.command, exp_o.surface, exp_o.disturbance, exp_o.speed,
                              rsp_current_command, rsp_surface_value,
                              rsp_disturbance_estimate, rsp_speed_estimate);
               end
            end
         end
         // Draw the receiver stall per transfer; long hold-off overrides
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_off_cycles <= 0;
      end else if (hold_off_req && hold_off_cycles == 0) begin
         hold_off_cycles <= 3000;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input longint value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BITS'(idx) << 2;
      csr_pwdata  <= DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      gain_reg[idx] = value & 64'h7FFF_FFFF;
   endtask

   task automatic wait_idle();
      while (pending_ticks.size() > 0 || expected_ticks.size() > 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   function automatic q16_type rand_q16();
      unique case ($urandom_range(0, 5))
         0: return q16_type'($urandom);
         1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return q16_type'($signed($urandom_range(0, 2 * 65536 * 400)) - 65536 * 400);
      endcase
   endfunction

   function automatic longint rand_gain();
      unique case ($urandom_range(0, 5))
         0: return 0;
         1: return 64'h7FFF_FFFF;
         2: return $urandom & 32'h7FFF_FFFF;
         default: return $urandom_range(0, 8 * 65536);
      endcase
   endfunction

   task automatic queue_random(input int count);
      tick_in_type t;
      for (int i = 0; i < count; i++) begin
         t.target_rpm   = rand_q16();
         t.measured_rpm = rand_q16();
         t.current_q    = rand_q16();
         pending_ticks.push_back(t);
      end
   endtask

   initial begin
      tick_in_type t;
      q16_type  corners [5];
      reset       = 1'b1;
      req_valid   = 1'b0;
      rsp_ready   = 1'b0;
      req_speed_target_rpm   = '0;
      req_speed_measured_rpm = '0;
      req_current_measured   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      hold_off_req = 1'b0;
      for (int i = 0; i < NUM_REGS; i++) gain_reg[i] = 0;
      gain_reg[REG_DGAIN] = ONE;
      clear_loop_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset gains (all zero but the torque gain) with extreme inputs
      corners[0] = 32'sh80000000;
      corners[1] = 32'sh7FFFFFFF;
      corners[2] = 0;
      corners[3] = 32'sh00010000;
      corners[4] = -32'sh00010000;
      for (int i = 0; i < 5; i++) begin
         t.target_rpm   = corners[i];
         t.measured_rpm = corners[4 - i];
         t.current_q    = corners[(i + 2) % 5];
         pending_ticks.push_back(t);
      end
      wait_idle();

      // Sign switching term, zero boundary, moderate gains
      csr_write(REG_SLOPE, 2 * ONE);
      csr_write(REG_LIN, ONE);
      csr_write(REG_SWITCH, ONE / 2);
      csr_write(REG_BOUND, 0);
      csr_write(REG_K1, ONE);
      csr_write(REG_K2, 3 * ONE);
      csr_write(REG_DAMP, ONE / 4);
      csr_write(REG_DGAIN, 2 * ONE);
      for (int i = 0; i < 10; i++) begin
         t.target_rpm   = corners[i % 5];
         t.measured_rpm = corners[(i * 3) % 5];
         t.current_q    = corners[(i + 1) % 5];
         pending_ticks.push_back(t);
      end
      wait_idle();

      // Zero torque gain forces a zero command; maxed boundary, slope and K1 gains
      csr_write(REG_DGAIN, 0);
      csr_write(REG_BOUND, 64'h7FFF_FFFF);
      csr_write(REG_SLOPE, 64'h7FFF_FFFF);
      csr_write(REG_K1, 64'h7FFF_FFFF);
      queue_random(8);
      wait_idle();

      // Random phases; the first one also holds off the receiver for long
      for (int phase = 0; phase < 8; phase++) begin
         for (int r = 0; r < NUM_REGS; r++) csr_write(r[2:0], rand_gain());
         if (phase == 0) hold_off_req = 1'b1;
         queue_random(100);
         if (phase == 0) wait (hold_off_cycles > 0);
         hold_off_req = 1'b0;
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("sliding_mode_speed_controller_top: match");
      end else begin
         $display("sliding_mode_speed_controller_top: mismatch");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("sliding_mode_speed_controller_top: mismatch");
      $finish;
   end

endmodule
